>>> src/ugb_pkg.sv
// Package for the uniform grid binning core: payload types, command and status codes.
// No dependencies.
`default_nettype none
package ugb_pkg;
  localparam int MAX_POINTS = 1024;
  localparam int MAX_CELLS = 4096;
  localparam int PW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_CELLS);
  localparam int NW = PW + 1;
  localparam logic [31:0] ONE_Q16 = 32'd65536;

  localparam logic [2:0] CMD_BEGIN = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_FINISH = 3'd2;
  localparam logic [2:0] CMD_RSLOT = 3'd3;
  localparam logic [2:0] CMD_RCELL = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_GRID = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [2:0] REG_SEP = 3'd0;
  localparam logic [2:0] REG_ALI = 3'd1;
  localparam logic [2:0] REG_COH = 3'd2;
  localparam logic [2:0] REG_XE = 3'd3;
  localparam logic [2:0] REG_YLO = 3'd4;
  localparam logic [2:0] REG_YHI = 3'd5;
  localparam logic [2:0] REG_ZE = 3'd6;

  typedef struct packed {
    logic [2:0] command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [11:0] lookup_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] point_number;
    logic [11:0] cell_number;
    logic [10:0] cell_start;
    logic [10:0] cell_population;
  } out_item_t;

  // Classified job handed from front to back.
  typedef struct packed {
    logic [2:0] command;
    logic [32:0] off_x;
    logic [32:0] off_y;
    logic [32:0] off_z;
    logic [11:0] lookup_index;
  } job_t;
endpackage
`default_nettype wire

>>> src/uniform_grid_binning_core.sv
// Top level of the uniform grid binning core: configuration registers, front and back.
// Depends on ugb_pkg, ugb_front, ugb_back.
// Bins Q16.16 points into a uniform grid by counting sort. Items queue in a two-entry
// front buffer; the back sequencer handles one command at a time. Add runs three
// 33-step divisions by the cell size plus a count read-modify-write; begin divides the
// spans by the cell size and then runs a count clearing sweep over all cells, during
// which no item is taken (the same sweep runs once after reset); finish forms prefix
// sums over the grid cells and then scatters the held points.
// Configuration writes are always accepted.
`default_nettype none
module uniform_grid_binning_core
  import ugb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [30:0] sep_r, ali_r, coh_r, xe_r, ze_r;
  logic signed [31:0] ylo_r, yhi_r;
  logic job_valid, job_take, clr_busy, fstall;
  job_t job;

  assign cfg_ready = 1'b1;
  assign in_stall = fstall || clr_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= 31'(ONE_Q16); ali_r <= 31'(ONE_Q16); coh_r <= 31'(ONE_Q16);
      xe_r <= 31'd1048576; ze_r <= 31'd1048576; ylo_r <= '0; yhi_r <= 32'sd1048576;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SEP: sep_r <= cfg_data[30:0];
        REG_ALI: ali_r <= cfg_data[30:0];
        REG_COH: coh_r <= cfg_data[30:0];
        REG_XE: xe_r <= cfg_data[30:0];
        REG_YLO: ylo_r <= cfg_data;
        REG_YHI: yhi_r <= cfg_data;
        REG_ZE: ze_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  ugb_front u_front (.clk, .rst_n, .in_valid(in_valid && !clr_busy), .in_stall(fstall),
    .in_data, .xe(xe_r), .ylo(ylo_r), .ze(ze_r), .job_valid, .job_take, .job);

  ugb_back u_back (.clk, .rst_n, .job_valid, .job_take, .job, .sep(sep_r), .ali(ali_r),
    .coh(coh_r), .xe(xe_r), .ylo(ylo_r), .yhi(yhi_r), .ze(ze_r), .clr_busy,
    .out_valid, .out_stall, .out_data);
endmodule
`default_nettype wire

>>> src/ugb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ugb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/ugb_front.sv
// Front end: accepts items, forms axis offsets from the world bounds, queues jobs.
// Depends on ugb_pkg.
`default_nettype none
module ugb_front
  import ugb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  input  wire logic [30:0]       xe,
  input  wire logic signed [31:0] ylo,
  input  wire logic [30:0]       ze,
  output logic                   job_valid,
  input  wire logic              job_take,
  output job_t                   job
);
  // two-entry queue
  job_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt;
  job_t nj;
  logic acc;

  always_comb begin
    nj.command = in_data.command;
    nj.off_x = {in_data.pos_x[31], in_data.pos_x} + {2'b0, xe};
    nj.off_y = {in_data.pos_y[31], in_data.pos_y} - {ylo[31], ylo};
    nj.off_z = {in_data.pos_z[31], in_data.pos_z} + {2'b0, ze};
    nj.lookup_index = in_data.lookup_index;
  end

  assign in_stall = (cnt_r == 2'd2);
  assign acc = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, acc} - {1'b0, job_take};
    rd_nxt = job_take ? !rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
    end
    if (acc) q_r[rd_r ^ cnt_r[0]] <= nj;
  end
endmodule
`default_nettype wire

>>> src/ugb_div.sv
// Radix-2 restoring divider: 33-bit dividend by 32-bit divisor, full 33-bit quotient.
// Depends on ugb_pkg.
`default_nettype none
module ugb_div
  import ugb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [32:0] num,
  input  wire logic [31:0] den,
  output logic             busy,
  output logic [32:0]      quo
);
  logic [32:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  n_r, n_nxt;
  logic [33:0] trial;

  assign busy = (n_r != 6'd0);
  assign quo = q_r;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    n_nxt = n_r;
    trial = {rem_r, q_r[32]} - {2'b0, den};
    if (start) begin
      q_nxt = num;
      rem_nxt = '0;
      n_nxt = 6'd33;
    end else if (busy) begin
      if (!trial[33]) begin
        rem_nxt = trial[32:0];
        q_nxt = {q_r[31:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[32]};
        q_nxt = {q_r[31:0], 1'b0};
      end
      n_nxt = n_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) n_r <= '0;
    else n_r <= n_nxt;
    q_r <= q_nxt;
    rem_r <= rem_nxt;
  end
endmodule
`default_nettype wire

>>> src/ugb_back.sv
// Back end: sequencer that runs begin/add/finish/read on the stores, one job at a time.
// Depends on ugb_pkg, ugb_div, ugb_ram.
`default_nettype none
module ugb_back
  import ugb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_take,
  input  wire job_t              job,
  input  wire logic [30:0]       sep,
  input  wire logic [30:0]       ali,
  input  wire logic [30:0]       coh,
  input  wire logic [30:0]       xe,
  input  wire logic signed [31:0] ylo,
  input  wire logic signed [31:0] yhi,
  input  wire logic [30:0]       ze,
  output logic                   clr_busy,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);
  localparam logic [4:0] S_IDLE = 5'd0, S_CLR = 5'd1, S_BDIV = 5'd2, S_BWAIT = 5'd3,
    S_BCHK = 5'd4, S_ADIV = 5'd5, S_AWAIT = 5'd6, S_AMUL1 = 5'd7, S_AMUL2 = 5'd8,
    S_ARD = 5'd9, S_AWR = 5'd10, S_PRE = 5'd11, S_PRE2 = 5'd12, S_FILL = 5'd13,
    S_FILL2 = 5'd14, S_FILL3 = 5'd15, S_RS = 5'd16, S_RS2 = 5'd17, S_RC = 5'd18,
    S_RC2 = 5'd19, S_OUT = 5'd20, S_BPROD = 5'd21, S_BPROD2 = 5'd22;

  logic [4:0]  st_r, st_nxt;
  logic [12:0] cl_r, cl_nxt;      // sweep / loop index
  logic [1:0]  ax_r, ax_nxt;      // axis under division
  logic [31:0] bin_r, bin_nxt;
  logic [12:0] dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [12:0] gx_r, gx_nxt, gy_r, gy_nxt, gz_r, gz_nxt;
  logic [25:0] p_r, p_nxt;
  logic [12:0] nc_r, nc_nxt;      // cell count, zero when the grid is invalid
  logic        ok_r, ok_nxt, dbad_r, dbad_nxt;
  logic [NW-1:0] held_r, held_nxt;
  logic [10:0] run_r, run_nxt;
  logic [CW-1:0] cell_r, cell_nxt;
  job_t        j_r, j_nxt;
  out_item_t   o_r, o_nxt, res_r, res_nxt;
  logic        ov_r, ov_nxt;

  logic        dstart, dbusy;
  logic [32:0] dnum, dq;
  logic [12:0] qc;
  logic [12:0] dim_sel;
  logic [32:0] off_sel;

  // stores
  logic          ta_we; logic [CW-1:0] ta_wa, ta_ra; logic [10:0] ta_wd, ta_rd;
  logic          ba_we; logic [CW-1:0] ba_ra; logic [10:0] ba_rd;
  logic          fc_we; logic [CW-1:0] fc_wa, fc_ra; logic [10:0] fc_wd, fc_rd;
  logic          pc_we; logic [PW-1:0] pc_wa, pc_ra; logic [CW-1:0] pc_wd, pc_rd;
  logic          sp_we; logic [PW-1:0] sp_wa, sp_ra; logic [PW-1:0] sp_wd, sp_rd;

  ugb_ram #(.WIDTH(11), .DEPTH(MAX_CELLS)) u_tally (.clk, .we(ta_we), .waddr(ta_wa),
    .wdata(ta_wd), .raddr(ta_ra), .rdata(ta_rd));
  ugb_ram #(.WIDTH(11), .DEPTH(MAX_CELLS)) u_base (.clk, .we(ba_we), .waddr(fc_wa),
    .wdata(fc_wd), .raddr(ba_ra), .rdata(ba_rd));
  ugb_ram #(.WIDTH(11), .DEPTH(MAX_CELLS)) u_cursor (.clk, .we(fc_we), .waddr(fc_wa),
    .wdata(fc_wd), .raddr(fc_ra), .rdata(fc_rd));
  ugb_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_pcell (.clk, .we(pc_we), .waddr(pc_wa),
    .wdata(pc_wd), .raddr(pc_ra), .rdata(pc_rd));
  ugb_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_sorted (.clk, .we(sp_we), .waddr(sp_wa),
    .wdata(sp_wd), .raddr(sp_ra), .rdata(sp_rd));

  ugb_div u_div (.clk, .rst_n, .start(dstart), .num(dnum), .den(bin_r), .busy(dbusy),
    .quo(dq));

  assign clr_busy = (st_r == S_CLR);
  assign out_valid = ov_r;
  assign out_data = o_r;
  assign qc = (dq[32:13] != '0) ? 13'h1FFF : dq[12:0];

  always_comb begin
    case (ax_r)
      2'd0: begin dim_sel = dx_r; off_sel = j_r.off_x; end
      2'd1: begin dim_sel = dy_r; off_sel = j_r.off_y; end
      default: begin dim_sel = dz_r; off_sel = j_r.off_z; end
    endcase
  end

  always_comb begin
    logic [31:0] m;
    logic [32:0] ys;
    logic [12:0] g;
    st_nxt = st_r; cl_nxt = cl_r; ax_nxt = ax_r; bin_nxt = bin_r;
    dx_nxt = dx_r; dy_nxt = dy_r; dz_nxt = dz_r;
    gx_nxt = gx_r; gy_nxt = gy_r; gz_nxt = gz_r; p_nxt = p_r; nc_nxt = nc_r;
    ok_nxt = ok_r; dbad_nxt = dbad_r; held_nxt = held_r; run_nxt = run_r;
    cell_nxt = cell_r; j_nxt = j_r; o_nxt = o_r; res_nxt = res_r; ov_nxt = ov_r;
    job_take = 1'b0; dstart = 1'b0; dnum = '0;
    ta_we = 1'b0; ta_wa = cl_r[CW-1:0]; ta_wd = '0; ta_ra = cl_r[CW-1:0];
    ba_we = 1'b0; ba_ra = j_r.lookup_index[CW-1:0];
    fc_we = 1'b0; fc_wa = cl_r[CW-1:0]; fc_wd = run_r; fc_ra = pc_rd;
    pc_we = 1'b0; pc_wa = held_r[PW-1:0]; pc_wd = cell_r; pc_ra = cl_r[PW-1:0];
    sp_we = 1'b0; sp_wa = fc_rd[PW-1:0]; sp_wd = cl_r[PW-1:0];
    sp_ra = j_r.lookup_index[PW-1:0];
    m = '0; ys = '0; g = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        ta_we = 1'b1;
        cl_nxt = cl_r + 13'd1;
        if (cl_r == 13'(MAX_CELLS - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (job_valid) begin
          job_take = 1'b1;
          j_nxt = job;
          res_nxt = '0;
          case (job.command)
            CMD_BEGIN: begin
              m = {1'b0, sep};
              if ({1'b0, ali} > m) m = {1'b0, ali};
              if ({1'b0, coh} > m) m = {1'b0, coh};
              bin_nxt = (m == '0) ? ONE_Q16 : m;
              held_nxt = '0;
              ax_nxt = 2'd0;
              dbad_nxt = 1'b0;
              st_nxt = S_BDIV;
            end
            CMD_ADD: begin
              if (!ok_r) begin res_nxt.status = ST_GRID; st_nxt = S_OUT; end
              else if (held_r >= NW'(MAX_POINTS)) begin
                res_nxt.status = ST_RANGE; st_nxt = S_OUT;
              end else begin ax_nxt = 2'd0; st_nxt = S_ADIV; end
            end
            CMD_FINISH: begin
              if (!ok_r) begin res_nxt.status = ST_GRID; st_nxt = S_OUT; end
              else begin cl_nxt = '0; run_nxt = '0; st_nxt = S_PRE; end
            end
            CMD_RSLOT: begin
              if ({1'b0, job.lookup_index} >= 13'(held_r) ||
                  job.lookup_index >= 12'(MAX_POINTS)) begin
                res_nxt.status = ST_RANGE; st_nxt = S_OUT;
              end else st_nxt = S_RS;
            end
            CMD_RCELL: begin
              if (!ok_r) begin res_nxt.status = ST_GRID; st_nxt = S_OUT; end
              else if ({1'b0, job.lookup_index} >= nc_r) begin
                res_nxt.status = ST_RANGE; st_nxt = S_OUT;
              end else st_nxt = S_RC;
            end
            default: begin res_nxt.status = ST_RANGE; st_nxt = S_OUT; end
          endcase
        end
      end
      // begin: dims = span / bin + 1, one axis at a time
      S_BDIV: begin
        dstart = 1'b1;
        ys = {yhi[31], yhi} - {ylo[31], ylo};
        case (ax_r)
          2'd0: dnum = {1'b0, xe, 1'b0};
          2'd1: dnum = ys[32] ? 33'(-$signed(ys)) : ys;
          default: dnum = {1'b0, ze, 1'b0};
        endcase
        st_nxt = S_BWAIT;
      end
      S_BWAIT: begin
        if (!dbusy) begin
          ys = {yhi[31], yhi} - {ylo[31], ylo};
          // negative y span: truncation toward zero gives -q, so dim = 1-q
          if (ax_r == 2'd1 && ys[32]) begin
            if (dq != '0) dbad_nxt = 1'b1;
            g = 13'd1;
          end else if (dq >= 33'(MAX_CELLS)) begin
            dbad_nxt = 1'b1; g = 13'(MAX_CELLS);
          end else g = dq[12:0] + 13'd1;
          case (ax_r)
            2'd0: dx_nxt = g;
            2'd1: dy_nxt = g;
            default: dz_nxt = g;
          endcase
          if (ax_r == 2'd2) st_nxt = S_BPROD;
          else begin ax_nxt = ax_r + 2'd1; st_nxt = S_BDIV; end
        end
      end
      S_BPROD: begin
        p_nxt = dx_r * dy_r;
        st_nxt = S_BPROD2;
      end
      S_BPROD2: begin
        if (p_r > 26'(MAX_CELLS)) dbad_nxt = 1'b1;
        else p_nxt = 26'(p_r[12:0] * dz_r);
        st_nxt = S_BCHK;
      end
      S_BCHK: begin
        ok_nxt = !dbad_r && (p_r <= 26'(MAX_CELLS));
        nc_nxt = ok_nxt ? p_r[12:0] : '0;
        res_nxt.status = ok_nxt ? ST_OK : ST_GRID;
        cl_nxt = '0;
        st_nxt = S_OUT;
      end
      // add
      S_ADIV: begin
        dstart = 1'b1;
        dnum = off_sel[32] ? '0 : off_sel;
        st_nxt = S_AWAIT;
      end
      S_AWAIT: begin
        if (!dbusy) begin
          g = (qc > dim_sel - 13'd1) ? dim_sel - 13'd1 : qc;
          case (ax_r)
            2'd0: gx_nxt = g;
            2'd1: gy_nxt = g;
            default: gz_nxt = g;
          endcase
          if (ax_r == 2'd2) st_nxt = S_AMUL1;
          else begin ax_nxt = ax_r + 2'd1; st_nxt = S_ADIV; end
        end
      end
      S_AMUL1: begin
        p_nxt = gz_r * dy_r;
        st_nxt = S_AMUL2;
      end
      S_AMUL2: begin
        cell_nxt = CW'(gx_r + CW'((p_r[12:0] + gy_r) * dx_r));
        st_nxt = S_ARD;
      end
      S_ARD: begin
        ta_ra = cell_r;
        st_nxt = S_AWR;
      end
      S_AWR: begin
        ta_we = 1'b1; ta_wa = cell_r; ta_wd = ta_rd + 11'd1;
        pc_we = 1'b1;
        res_nxt.point_number = 10'(held_r);
        res_nxt.cell_number = 12'(cell_r);
        held_nxt = held_r + NW'(1);
        st_nxt = S_OUT;
      end
      // finish: prefix sums, then scatter
      S_PRE: begin
        if (cl_r >= nc_r) begin cl_nxt = '0; st_nxt = S_FILL; end
        else begin ta_ra = cl_r[CW-1:0]; st_nxt = S_PRE2; end
      end
      S_PRE2: begin
        ba_we = 1'b1; fc_we = 1'b1;
        run_nxt = run_r + ta_rd;
        cl_nxt = cl_r + 13'd1;
        st_nxt = S_PRE;
      end
      S_FILL: begin
        if (cl_r >= 13'(held_r)) st_nxt = S_OUT;
        else st_nxt = S_FILL2;
      end
      S_FILL2: st_nxt = S_FILL3; // cursor read issued from point cell
      S_FILL3: begin
        sp_we = 1'b1;
        fc_we = 1'b1; fc_wa = pc_rd; fc_wd = fc_rd + 11'd1;
        cl_nxt = cl_r + 13'd1;
        st_nxt = S_FILL;
      end
      S_RS: st_nxt = S_RS2;
      S_RS2: begin
        res_nxt.point_number = sp_rd;
        st_nxt = S_OUT;
      end
      S_RC: begin ta_ra = j_r.lookup_index[CW-1:0]; st_nxt = S_RC2; end
      S_RC2: begin
        res_nxt.cell_number = j_r.lookup_index;
        res_nxt.cell_start = ba_rd;
        res_nxt.cell_population = ta_rd;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          o_nxt = res_r;
          ov_nxt = 1'b1;
          st_nxt = (j_r.command == CMD_BEGIN) ? S_CLR : S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cl_r <= '0; ov_r <= 1'b0; ok_r <= 1'b0; held_r <= '0;
      bin_r <= ONE_Q16; dx_r <= '0; dy_r <= '0; dz_r <= '0; nc_r <= '0;
    end else begin
      st_r <= st_nxt; cl_r <= cl_nxt; ov_r <= ov_nxt; ok_r <= ok_nxt;
      held_r <= held_nxt; bin_r <= bin_nxt; dx_r <= dx_nxt; dy_r <= dy_nxt;
      dz_r <= dz_nxt; nc_r <= nc_nxt;
    end
    ax_r <= ax_nxt; gx_r <= gx_nxt; gy_r <= gy_nxt; gz_r <= gz_nxt; p_r <= p_nxt;
    dbad_r <= dbad_nxt; run_r <= run_nxt; cell_r <= cell_nxt; j_r <= j_nxt;
    o_r <= o_nxt; res_r <= res_nxt;
  end
endmodule
`default_nettype wire

>>> src/ugb_checker.sv
// Port-level checker for the uniform grid binning core, bound to the top level.
// Depends on ugb_pkg.
`default_nettype none
module ugb_checker
  import ugb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data,
  input wire logic      cfg_ready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result dropped");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3) else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.cell_population == '0)
    else $error("error result carries data");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg not ready");
endmodule

bind uniform_grid_binning_core ugb_checker u_chk (.clk, .rst_n, .out_valid, .out_stall,
  .out_data, .cfg_ready);
`default_nettype wire
